// ===== rtl/core/cbd_pkg.sv =====
// shared types, constants and a helper function of the chunked body decoder
// no dependencies; imported by the register block and the core
`timescale 1ns / 1ps

package cbd_pkg;

   localparam int unsigned SIZE_BITS_DEFAULT = 32;
   localparam int unsigned CSR_ADDR_BITS     = 3;
   localparam int unsigned CSR_DATA_BITS     = 32;

   localparam logic [CSR_DATA_BITS-1:0] MAX_BODY_RESET = 32'd1048576;

   // register index, taken from word address bit
   localparam logic CSR_IDX_MAX_BODY = 1'b0;

   localparam logic [7:0] CHAR_CR    = 8'h0d;
   localparam logic [7:0] CHAR_LF    = 8'h0a;
   localparam logic [7:0] CHAR_ZERO  = 8'h30;
   localparam logic [7:0] CHAR_LOW_A = 8'h61;
   localparam logic [7:0] CHAR_UP_A  = 8'h41;
   localparam logic [7:0] HEX_TEN    = 8'd10;

   typedef enum logic [1:0] {
      PH_SIZE = 2'd0,
      PH_DATA = 2'd1,
      PH_CRLF = 2'd2,
      PH_DONE = 2'd3
   } phase_type;

   typedef enum logic [1:0] {
      ERR_NONE      = 2'd0,
      ERR_CRLF      = 2'd1,
      ERR_OVERFLOW  = 2'd2,
      ERR_TOO_LARGE = 2'd3
   } err_type;

   typedef struct packed {
      logic       is_hex;
      logic [3:0] value;
   } hex_digit_type;

   function automatic hex_digit_type hex_decode(input logic [7:0] b);
      hex_digit_type d;
      logic [7:0]    v;
      d = '0;
      v = '0;
      case (b) inside
         [8'h30:8'h39]: begin
            v = b - CHAR_ZERO;
            d.is_hex = 1'b1;
         end
         [8'h61:8'h66]: begin
            v = b - CHAR_LOW_A + HEX_TEN;
            d.is_hex = 1'b1;
         end
         [8'h41:8'h46]: begin
            v = b - CHAR_UP_A + HEX_TEN;
            d.is_hex = 1'b1;
         end
         default: begin
            d.is_hex = 1'b0;
         end
      endcase
      d.value = v[3:0];
      return d;
   endfunction

endpackage

// ===== rtl/core/cbd_req_if.sv =====
// input channel of the chunked body decoder: one raw body byte per transfer
// standalone, uses nothing from cbd_pkg
`timescale 1ns / 1ps

interface cbd_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] body_byte;
   logic       start_of_body;

   modport source (output valid, output body_byte, output start_of_body, input ready);
   modport sink   (input valid, input body_byte, input start_of_body, output ready);
endinterface

// ===== rtl/core/cbd_rsp_if.sv =====
// result channel of the chunked body decoder: one result per accepted byte
// standalone, no package needed
`timescale 1ns / 1ps

interface cbd_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] payload_byte;
   logic       payload_valid;
   logic       body_done;
   logic [1:0] error_code;

   modport source (output valid, output payload_byte, output payload_valid,
                   output body_done, output error_code, input ready);
   modport sink   (input valid, input payload_byte, input payload_valid,
                   input body_done, input error_code, output ready);
endinterface

// ===== rtl/core/cbd_csr.sv =====
// apb-style register block of the chunked body decoder (max body size)
// depends on cbd_pkg
`timescale 1ns / 1ps

module cbd_csr (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               psel,
   input  logic                               penable,
   input  logic                               pwrite,
   input  logic [cbd_pkg::CSR_ADDR_BITS-1:0]  paddr,
   input  logic [cbd_pkg::CSR_DATA_BITS-1:0]  pwdata,
   output logic [cbd_pkg::CSR_DATA_BITS-1:0]  prdata,
   output logic                               pready,
   output logic [cbd_pkg::CSR_DATA_BITS-1:0]  size_limit
);
   import cbd_pkg::*;

   logic [CSR_DATA_BITS-1:0] max_body_ff;
   logic [CSR_DATA_BITS-1:0] max_body_in;
   logic                     wr_stb;
   logic                     hit_max_body;

   assign pready       = 1'b1;
   assign hit_max_body = (paddr[2] == CSR_IDX_MAX_BODY);
   assign wr_stb       = psel && penable && pwrite && pready;

   always_comb begin
      max_body_in = max_body_ff;
      if (wr_stb && hit_max_body) begin
         max_body_in = pwdata;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         max_body_ff <= MAX_BODY_RESET;
      end else begin
         max_body_ff <= max_body_in;
      end
   end

   assign prdata     = hit_max_body ? max_body_ff : '0;
   assign size_limit = max_body_ff;

endmodule

// ===== rtl/core/chunked_body_decoder_core.sv =====
// top level of the chunked body decoder: byte-wise state update and result register
// depends on cbd_pkg, cbd_req_if, cbd_rsp_if and cbd_csr
`timescale 1ns / 1ps

// Decodes an HTTP/1.1 chunked body taken one byte per transfer on req and gives
// exactly one result per byte on rsp through a registered result. A byte is
// accepted every clock as long as the result register is empty or being drained in
// the same cycle, so the sustained rate is one byte per cycle; the only thing that
// holds it back is rsp.ready, through the single result register. A size line gives
// the chunk size from its leading hex digits (SIZE_BITS wide), anything after the
// first non-hex byte is skipped up to CR LF, a size of zero ends the body and sets
// body_done until start_of_body. Payload bytes come out with payload_valid set; the
// CR LF after each chunk is checked. Errors (missing CR LF, size overflow, body larger
// than the configured limit) are sticky and the decoder ignores bytes until a byte
// arrives with start_of_body set, which clears all state before that byte is decoded.
// the body size limit register sits at byte address 0 of the apb port and should only
// be written while no byte is in flight.

module chunked_body_decoder_core #(
   parameter int unsigned SIZE_BITS = cbd_pkg::SIZE_BITS_DEFAULT
) (
   input  logic                               clock,
   input  logic                               reset,
   cbd_req_if.sink                            req,
   cbd_rsp_if.source                          rsp,
   input  logic                               psel,
   input  logic                               penable,
   input  logic                               pwrite,
   input  logic [cbd_pkg::CSR_ADDR_BITS-1:0]  paddr,
   input  logic [cbd_pkg::CSR_DATA_BITS-1:0]  pwdata,
   output logic [cbd_pkg::CSR_DATA_BITS-1:0]  prdata,
   output logic                               pready
);
   import cbd_pkg::*;

   // decoder state
   phase_type                phase_ff,     phase_in;
   logic                     saw_cr_ff,    saw_cr_in;
   logic                     in_prefix_ff, in_prefix_in;
   logic [SIZE_BITS-1:0]     accum_ff,     accum_in;
   logic [SIZE_BITS-1:0]     left_ff,      left_in;
   logic [31:0]              count_ff,     count_in;
   err_type                  err_ff,       err_in;

   // result register
   logic                     rsp_valid_ff,   rsp_valid_in;
   logic [7:0]               rsp_byte_ff,    rsp_byte_in;
   logic                     rsp_pvalid_ff,  rsp_pvalid_in;
   logic                     rsp_done_ff,    rsp_done_in;
   err_type                  rsp_err_ff,     rsp_err_in;

   logic [CSR_DATA_BITS-1:0] size_limit;
   logic                     in_xfer;
   logic                     out_xfer;

   // state as seen after an optional start-of-body clear
   phase_type                ph_cur;
   logic                     saw_cr_cur;
   logic                     in_prefix_cur;
   logic [SIZE_BITS-1:0]     accum_cur;
   logic [SIZE_BITS-1:0]     left_cur;
   logic [31:0]              count_cur;
   err_type                  err_cur;
   hex_digit_type            digit;
   logic [SIZE_BITS-1:0]     left_dec;
   logic                     emit;

   cbd_csr u_csr (
      .clock      (clock),
      .reset      (reset),
      .psel       (psel),
      .penable    (penable),
      .pwrite     (pwrite),
      .paddr      (paddr),
      .pwdata     (pwdata),
      .prdata     (prdata),
      .pready     (pready),
      .size_limit (size_limit)
   );

   // take a new byte whenever the result register is free or drains this cycle
   assign req.ready = !rsp_valid_ff || rsp.ready;
   assign in_xfer   = req.valid && req.ready;
   assign out_xfer  = rsp_valid_ff && rsp.ready;

   assign digit    = hex_decode(req.body_byte);
   assign left_dec = left_cur - {{(SIZE_BITS-1){1'b0}}, 1'b1};

   // next state and result for the byte on the input
   always_comb begin
      if (req.start_of_body) begin
         ph_cur        = PH_SIZE;
         saw_cr_cur    = 1'b0;
         in_prefix_cur = 1'b1;
         accum_cur     = '0;
         left_cur      = '0;
         count_cur     = '0;
         err_cur       = ERR_NONE;
      end else begin
         ph_cur        = phase_ff;
         saw_cr_cur    = saw_cr_ff;
         in_prefix_cur = in_prefix_ff;
         accum_cur     = accum_ff;
         left_cur      = left_ff;
         count_cur     = count_ff;
         err_cur       = err_ff;
      end

      phase_in     = ph_cur;
      saw_cr_in    = saw_cr_cur;
      in_prefix_in = in_prefix_cur;
      accum_in     = accum_cur;
      left_in      = left_cur;
      count_in     = count_cur;
      err_in       = err_cur;
      emit         = 1'b0;

      if (err_cur == ERR_NONE) begin
         case (ph_cur)
            PH_SIZE: begin
               if (saw_cr_cur && req.body_byte == CHAR_LF) begin
                  // end of size line: zero size finishes the body
                  saw_cr_in    = 1'b0;
                  in_prefix_in = 1'b1;
                  if (accum_cur == '0) begin
                     phase_in = PH_DONE;
                  end else begin
                     left_in  = accum_cur;
                     accum_in = '0;
                     phase_in = PH_DATA;
                  end
               end else if (req.body_byte == CHAR_CR) begin
                  saw_cr_in    = 1'b1;
                  in_prefix_in = 1'b0;
               end else begin
                  saw_cr_in = 1'b0;
                  if (in_prefix_cur && digit.is_hex) begin
                     // any set bit in the top nibble would be shifted out
                     if (accum_cur[SIZE_BITS-1 -: 4] != 4'd0) begin
                        err_in = ERR_OVERFLOW;
                     end else begin
                        accum_in = {accum_cur[SIZE_BITS-5:0], digit.value};
                     end
                  end else begin
                     // extension or junk: skip until cr lf
                     in_prefix_in = 1'b0;
                  end
               end
            end
            PH_DATA: begin
               if (count_cur >= size_limit) begin
                  err_in = ERR_TOO_LARGE;
               end else begin
                  emit     = 1'b1;
                  count_in = count_cur + 32'd1;
                  left_in  = left_dec;
                  if (left_dec == '0) begin
                     phase_in  = PH_CRLF;
                     saw_cr_in = 1'b0;
                  end
               end
            end
            PH_CRLF: begin
               if (!saw_cr_cur && req.body_byte == CHAR_CR) begin
                  saw_cr_in = 1'b1;
               end else if (saw_cr_cur && req.body_byte == CHAR_LF) begin
                  saw_cr_in    = 1'b0;
                  in_prefix_in = 1'b1;
                  accum_in     = '0;
                  phase_in     = PH_SIZE;
               end else begin
                  err_in = ERR_CRLF;
               end
            end
            default: begin
               // done: bytes are ignored
            end
         endcase
      end

      rsp_byte_in   = emit ? req.body_byte : 8'd0;
      rsp_pvalid_in = emit;
      rsp_done_in   = (phase_in == PH_DONE);
      rsp_err_in    = err_in;

      rsp_valid_in = rsp_valid_ff;
      if (in_xfer) begin
         rsp_valid_in = 1'b1;
      end else if (out_xfer) begin
         rsp_valid_in = 1'b0;
      end
   end

   // decoder state, advanced on each input transfer
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= PH_SIZE;
         saw_cr_ff    <= 1'b0;
         in_prefix_ff <= 1'b1;
         accum_ff     <= '0;
         left_ff      <= '0;
         count_ff     <= '0;
         err_ff       <= ERR_NONE;
      end else if (in_xfer) begin
         phase_ff     <= phase_in;
         saw_cr_ff    <= saw_cr_in;
         in_prefix_ff <= in_prefix_in;
         accum_ff     <= accum_in;
         left_ff      <= left_in;
         count_ff     <= count_in;
         err_ff       <= err_in;
      end
   end

   // result register valid flag
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // result payload, loaded with each input transfer
   always_ff @(posedge clock) begin
      if (in_xfer) begin
         rsp_byte_ff   <= rsp_byte_in;
         rsp_pvalid_ff <= rsp_pvalid_in;
         rsp_done_ff   <= rsp_done_in;
         rsp_err_ff    <= rsp_err_in;
      end
   end

   assign rsp.valid         = rsp_valid_ff;
   assign rsp.payload_byte  = rsp_byte_ff;
   assign rsp.payload_valid = rsp_pvalid_ff;
   assign rsp.body_done     = rsp_done_ff;
   assign rsp.error_code    = rsp_err_ff;

   // an error holds until a byte with start of body clears it
   a_err_sticky: assert property (@(posedge clock) disable iff (reset)
      (in_xfer && !req.start_of_body && err_ff != ERR_NONE) |=> (err_ff == $past(err_ff)))
      else $error("sticky error changed without start of body");

   // a payload byte never goes out together with an error or a finished body
   a_payload_clean: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_pvalid_ff) |-> (rsp_err_ff == ERR_NONE && !rsp_done_ff))
      else $error("payload byte flagged with error or done");

   // data phase always has bytes left to pass out
   a_data_left: assert property (@(posedge clock) disable iff (reset)
      (phase_ff == PH_DATA && err_ff == ERR_NONE) |-> (left_ff != '0))
      else $error("data phase with no bytes left");

endmodule
